>>> sv/tcw_pkg.sv
// tcw_pkg: shared constants, types and codes of the text console writer
// used by tcw_cell_ram and text_console_writer; no dependencies
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int LAST_ROW   = 24;
  localparam int ROW_COUNT  = LAST_ROW + 1;
  localparam int CELL_COUNT = COLUMNS * ROW_COUNT;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROW_COUNT);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [7:0]        byte_t;

  // cell layout: attribute in the high byte, character in the low byte
  typedef struct packed {
    byte_t attr;
    byte_t char_code;
  } cell_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    cell_t data;
  } ram_wr_t;

  localparam byte_t SPACE_CODE   = 8'h20;
  localparam byte_t NEWLINE_CODE = 8'h0A;
  localparam byte_t NUL_CODE     = 8'h00;
  localparam byte_t INIT_ATTR    = 8'h07;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_ACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_TEXT_ATTR  = 2'd0,
    REG_BLANK_ATTR = 2'd1
  } reg_idx_t;

endpackage

>>> sv/tcw_cell_ram.sv
// tcw_cell_ram: single write port, single registered read port cell store
// depends on tcw_pkg for the depth and the cell layout
module tcw_cell_ram (
  input  logic             clk,
  input  tcw_pkg::ram_wr_t wr,
  input  tcw_pkg::addr_t   rd_addr,
  output tcw_pkg::cell_t   rd_data
);

  tcw_pkg::cell_t mem [tcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/text_console_writer.sv
// text_console_writer: text-mode console with cell store, cursor and changed flag
// depends on tcw_pkg and tcw_cell_ram
//
//  channel  ports                                      handshake
//  input    in_action in_char_code in_cell_index       start & !busy
//  result   out_cursor_* out_read_* out_screen_changed out_valid, one cycle
//  config   cfg_index cfg_data                         cfg_valid & cfg_ready
//
// nul, plain character and acknowledge are done in the accept cycle; read cell waits in S_READ for the ram data
// clear screen: a fill sweep over all CELL_COUNT cells, one cell a cycle through the cell ram port
// character or newline that scrolls: row copy in S_SCROLL, then blank row in S_FILL
// after reset a clearing pass over the whole store keeps busy high
// results cannot be stalled; config writes are taken in every cycle
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_position,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attribute,
  output logic        out_screen_changed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_FILL   = 4'b1000
  } state_t;

  localparam tcw_pkg::addr_t LAST_POS  = tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1);
  localparam tcw_pkg::addr_t ROW_STEP  = tcw_pkg::addr_t'(tcw_pkg::COLUMNS);
  localparam tcw_pkg::addr_t LAST_BASE =
    tcw_pkg::addr_t'(tcw_pkg::LAST_ROW * tcw_pkg::COLUMNS);
  localparam tcw_pkg::col_t  LAST_COL  = tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1);
  localparam tcw_pkg::row_t  LAST_ROWV = tcw_pkg::row_t'(tcw_pkg::LAST_ROW);

  state_t             state_r, state_nxt;
  tcw_pkg::addr_t     addr_r, addr_nxt;
  tcw_pkg::byte_t     fill_attr_r, fill_attr_nxt;
  logic               emit_r, emit_nxt;
  logic               read_ok_r, read_ok_nxt;
  tcw_pkg::col_t      col_r, col_nxt;
  tcw_pkg::row_t      row_r, row_nxt;
  tcw_pkg::addr_t     pos_r, pos_nxt;
  logic               changed_r, changed_nxt;
  tcw_pkg::byte_t     text_attr_r, blank_attr_r;
  logic               out_valid_r;
  logic [6:0]         out_col_r;
  logic [4:0]         out_row_r;
  logic [10:0]        out_pos_r;
  tcw_pkg::byte_t     out_char_r, out_attr_r;
  logic               out_changed_r;

  tcw_pkg::ram_wr_t   ram_wr;
  tcw_pkg::addr_t     rd_addr;
  tcw_pkg::cell_t     rd_data;
  logic               accept;
  logic               finish;
  tcw_pkg::byte_t     fin_char, fin_attr;
  tcw_pkg::action_t   action;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign action    = tcw_pkg::action_t'(in_action);

  tcw_cell_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    fill_attr_nxt = fill_attr_r;
    emit_nxt      = emit_r;
    read_ok_nxt   = read_ok_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    changed_nxt   = changed_r;
    ram_wr        = '0;
    rd_addr       = addr_r + 1'b1;
    finish        = 1'b0;
    fin_char      = '0;
    fin_attr      = '0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = ROW_STEP;
        if (accept) begin
          case (action)
            tcw_pkg::ACT_WRITE: begin
              logic new_row;
              new_row     = 1'b0;
              changed_nxt = 1'b1;
              if (in_char_code == tcw_pkg::NEWLINE_CODE) begin
                new_row = 1'b1;
              end else if (in_char_code != tcw_pkg::NUL_CODE) begin
                ram_wr.en             = 1'b1;
                ram_wr.addr           = pos_r;
                ram_wr.data.attr      = text_attr_r;
                ram_wr.data.char_code = in_char_code;
                if (col_r == LAST_COL) begin
                  new_row = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                  pos_nxt = pos_r + 1'b1;
                end
              end
              if (new_row) begin
                col_nxt = '0;
                if (row_r == LAST_ROWV) begin
                  // cursor stays on the last row, the rows move up under it
                  pos_nxt   = LAST_BASE;
                  addr_nxt  = ROW_STEP;
                  state_nxt = S_SCROLL;
                end else begin
                  row_nxt = row_r + 1'b1;
                  pos_nxt = pos_r - tcw_pkg::addr_t'(col_r) + ROW_STEP;
                end
              end
              finish = (state_nxt == S_IDLE);
            end
            tcw_pkg::ACT_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              pos_nxt       = '0;
              changed_nxt   = 1'b1;
              addr_nxt      = '0;
              fill_attr_nxt = text_attr_r;
              emit_nxt      = 1'b1;
              state_nxt     = S_FILL;
            end
            tcw_pkg::ACT_READ: begin
              rd_addr     = tcw_pkg::addr_t'(in_cell_index);
              read_ok_nxt = (32'(in_cell_index) < tcw_pkg::CELL_COUNT);
              state_nxt   = S_READ;
            end
            default: begin
              changed_nxt = 1'b0;
              finish      = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        finish    = 1'b1;
        state_nxt = S_IDLE;
        if (read_ok_r) begin
          fin_char = rd_data.char_code;
          fin_attr = rd_data.attr;
        end
      end
      S_SCROLL: begin
        // addr_r was read last cycle; its cell moves one row up
        ram_wr.en   = 1'b1;
        ram_wr.addr = addr_r - ROW_STEP;
        ram_wr.data = rd_data;
        if (addr_r == LAST_POS) begin
          addr_nxt      = LAST_BASE;
          fill_attr_nxt = blank_attr_r;
          emit_nxt      = 1'b1;
          state_nxt     = S_FILL;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_FILL: begin
        ram_wr.en             = 1'b1;
        ram_wr.addr           = addr_r;
        ram_wr.data.attr      = fill_attr_r;
        ram_wr.data.char_code = tcw_pkg::SPACE_CODE;
        if (addr_r == LAST_POS) begin
          state_nxt = S_IDLE;
          finish    = emit_r;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // clearing pass over the whole store in the reset attribute
      state_r      <= S_FILL;
      addr_r       <= '0;
      fill_attr_r  <= tcw_pkg::INIT_ATTR;
      emit_r       <= 1'b0;
      read_ok_r    <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      pos_r        <= '0;
      changed_r    <= 1'b0;
      text_attr_r  <= tcw_pkg::INIT_ATTR;
      blank_attr_r <= tcw_pkg::INIT_ATTR;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      fill_attr_r <= fill_attr_nxt;
      emit_r      <= emit_nxt;
      read_ok_r   <= read_ok_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= finish;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tcw_pkg::REG_TEXT_ATTR:  text_attr_r  <= cfg_data;
          tcw_pkg::REG_BLANK_ATTR: blank_attr_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_col_r     <= 7'(col_nxt);
      out_row_r     <= 5'(row_nxt);
      out_pos_r     <= 11'(pos_nxt);
      out_char_r    <= fin_char;
      out_attr_r    <= fin_attr;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_column   = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_char       = out_char_r;
  assign out_read_attribute  = out_attr_r;
  assign out_screen_changed  = out_changed_r;

  a_clear_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == tcw_pkg::ACT_CLEAR) |=> busy)
    else $error("clear screen did not start a fill sweep");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> $past(accept && in_action == tcw_pkg::ACT_READ))
    else $error("read wait entered without a read item");

  a_scroll_source_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (32'(addr_r) >= tcw_pkg::COLUMNS))
    else $error("scroll source below the second row");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_row) <= tcw_pkg::LAST_ROW &&
                   32'(out_cursor_column) < tcw_pkg::COLUMNS))
    else $error("cursor outside the screen");

  a_position_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_position) ==
      ((32'(out_cursor_row) * tcw_pkg::COLUMNS + 32'(out_cursor_column)) & 32'h7FF)))
    else $error("linear cursor position out of step with column and row");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for text_console_writer, a directed table then random phases
// depends on tcw_pkg and the text_console_writer rtl; reports are checked against a shadow console
module tb_top;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 30;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 10 * (tcw_pkg::CELL_COUNT + 1);

  // indexes past the two attribute registers, which the block ignores
  localparam logic [1:0] FIRST_SPARE_REG = 2'd2;

  typedef struct packed {
    logic [6:0]      col;
    logic [4:0]      row;
    logic [10:0]     pos;
    tcw_pkg::byte_t  rd_char;
    tcw_pkg::byte_t  rd_attr;
    logic            changed;
  } cursor_report_t;

  typedef struct packed {
    tcw_pkg::action_t act;
    tcw_pkg::byte_t   ch;
    tcw_pkg::addr_t   idx;
    logic             typed;
    cursor_report_t   want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_char_code = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_valid;
  logic [6:0]  out_cursor_column;
  logic [4:0]  out_cursor_row;
  logic [10:0] out_cursor_position;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attribute;
  logic        out_screen_changed;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // typed expectation travelling with the item, moved like the item fields
  logic           row_typed = 1'b0;
  cursor_report_t row_want = '0;

  text_console_writer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_cursor_column   (out_cursor_column),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_position (out_cursor_position),
    .out_read_char       (out_read_char),
    .out_read_attribute  (out_read_attribute),
    .out_screen_changed  (out_screen_changed),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // shadow console
  tcw_pkg::cell_t shadow_cells [tcw_pkg::CELL_COUNT];
  int unsigned    shadow_col;
  int unsigned    shadow_row;
  logic           shadow_changed;
  tcw_pkg::byte_t shadow_text_attr;
  tcw_pkg::byte_t shadow_blank_attr;

  cursor_report_t expected_reports [$];
  int items_issued  = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int scroll_count  = 0;
  int clear_count   = 0;
  int read_count    = 0;
  int attr_settings = 0;
  int quiet_cycles  = 0;

  function automatic void shadow_newline();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row > tcw_pkg::LAST_ROW) begin
      for (int i = 0; i < tcw_pkg::COLUMNS * tcw_pkg::LAST_ROW; i++) begin
        shadow_cells[i] = shadow_cells[i + tcw_pkg::COLUMNS];
      end
      for (int i = tcw_pkg::COLUMNS * tcw_pkg::LAST_ROW; i < tcw_pkg::CELL_COUNT; i++)
        shadow_cells[i] = {shadow_blank_attr, tcw_pkg::SPACE_CODE};
      shadow_row = tcw_pkg::LAST_ROW;
      scroll_count++;
    end
  endfunction

  function automatic cursor_report_t shadow_step(tcw_pkg::action_t act, tcw_pkg::byte_t ch,
                                                 tcw_pkg::addr_t idx);
    cursor_report_t r;
    r = '0;
    case (act)
      tcw_pkg::ACT_WRITE: begin
        shadow_changed = 1'b1;
        if (ch == tcw_pkg::NEWLINE_CODE) begin
          shadow_newline();
        end else if (ch != tcw_pkg::NUL_CODE) begin
          shadow_cells[shadow_row * tcw_pkg::COLUMNS + shadow_col] = {shadow_text_attr, ch};
          shadow_col++;
          if (shadow_col > tcw_pkg::COLUMNS - 1) shadow_newline();
        end
      end
      tcw_pkg::ACT_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) begin
          shadow_cells[i] = {shadow_text_attr, tcw_pkg::SPACE_CODE};
        end
        shadow_col = 0;
        shadow_row = 0;
        shadow_changed = 1'b1;
        clear_count++;
      end
      tcw_pkg::ACT_READ: begin
        read_count++;
        if (idx < tcw_pkg::CELL_COUNT) begin
          r.rd_char = shadow_cells[idx].char_code;
          r.rd_attr = shadow_cells[idx].attr;
        end
      end
      default: shadow_changed = 1'b0;
    endcase
    r.col     = 7'(shadow_col);
    r.row     = 5'(shadow_row);
    r.pos     = 11'(shadow_row * tcw_pkg::COLUMNS + shadow_col);
    r.changed = shadow_changed;
    return r;
  endfunction

  always @(posedge clk) begin : report_check
    cursor_report_t want;
    if (!rst_n) begin
      for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) begin
        shadow_cells[i] = {tcw_pkg::INIT_ATTR, tcw_pkg::SPACE_CODE};
      end
      shadow_col = 0;
      shadow_row = 0;
      shadow_changed = 1'b0;
      shadow_text_attr = tcw_pkg::INIT_ATTR;
      shadow_blank_attr = tcw_pkg::INIT_ATTR;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tcw_pkg::REG_TEXT_ATTR) shadow_text_attr = cfg_data;
        else if (cfg_index == tcw_pkg::REG_BLANK_ATTR) shadow_blank_attr = cfg_data;
      end
      if (start && !busy) begin
        want = shadow_step(tcw_pkg::action_t'(in_action), in_char_code, in_cell_index);
        if (row_typed) want = row_want;
        expected_reports.push_back(want);
      end
      if (out_valid) begin
        results_seen++;
        if (expected_reports.size() == 0) begin
          $error("report arrived with no item outstanding");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_cursor_column !== want.col) begin
            $error("cursor_column: expected %0d, got %0d", want.col, out_cursor_column);
            fail_count++;
          end
          if (out_cursor_row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, out_cursor_row);
            fail_count++;
          end
          if (out_cursor_position !== want.pos) begin
            $error("cursor_position: expected %0d, got %0d", want.pos, out_cursor_position);
            fail_count++;
          end
          if (out_read_char !== want.rd_char) begin
            $error("read_char: expected %h, got %h", want.rd_char, out_read_char);
            fail_count++;
          end
          if (out_read_attribute !== want.rd_attr) begin
            $error("read_attribute: expected %h, got %h", want.rd_attr, out_read_attribute);
            fail_count++;
          end
          if (out_screen_changed !== want.changed) begin
            $error("screen_changed: expected %0d, got %0d", want.changed, out_screen_changed);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic issue_item(tcw_pkg::action_t act, tcw_pkg::byte_t ch, tcw_pkg::addr_t idx,
                            logic typed, cursor_report_t want);
    start         <= 1'b1;
    in_action     <= act;
    in_char_code  <= ch;
    in_cell_index <= idx;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk); while (busy);
    items_issued++;
  endtask

  task automatic idle_gap(bit allow);
    int n = 0;
    int pick;
    pick = $urandom_range(0, 99);
    if (allow) begin
      if (pick < 40) n = 0;
      else if (pick < 85) n = $urandom_range(1, 3);
      else if (pick < 97) n = $urandom_range(4, 12);
      else n = $urandom_range(20, 60);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send(tcw_pkg::action_t act, tcw_pkg::byte_t ch, tcw_pkg::addr_t idx,
                      bit gaps);
    issue_item(act, ch, idx, 1'b0, '0);
    idle_gap(gaps);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (results_seen != items_issued || busy) @(posedge clk);
  endtask

  task automatic set_attrs(tcw_pkg::byte_t text_attr, tcw_pkg::byte_t blank_attr);
    logic [1:0]     idx_seq [3];
    tcw_pkg::byte_t data_seq [3];
    idx_seq[0]  = tcw_pkg::REG_TEXT_ATTR;
    idx_seq[1]  = tcw_pkg::REG_BLANK_ATTR;
    idx_seq[2]  = FIRST_SPARE_REG + 2'($urandom_range(0, 1));
    data_seq[0] = text_attr;
    data_seq[1] = blank_attr;
    data_seq[2] = 8'($urandom);
    wait_drained();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_seq[k];
      cfg_data  <= data_seq[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    attr_settings++;
  endtask

  initial begin : stimulus
    table_row_t     directed_rows [$];
    int             phase_items;
    int             pick;
    int             len;
    int             back;
    int             pos;
    bit             gaps_on;
    tcw_pkg::addr_t idx;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // after reset every cell is a space in attribute 7
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd0, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, tcw_pkg::SPACE_CODE, tcw_pkg::INIT_ATTR, 1'b0}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'hFF, 11'd1999, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, tcw_pkg::SPACE_CODE, tcw_pkg::INIT_ATTR, 1'b0}});
    // reads past the last cell return zeros
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd2000, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, 8'h00, 8'h00, 1'b0}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd2047, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, 8'h00, 8'h00, 1'b0}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_ACK, 8'h00, 11'd0, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, 8'h00, 8'h00, 1'b0}});
    // nul only marks the screen changed
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, tcw_pkg::NUL_CODE, 11'd2047, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, 8'h00, 8'h00, 1'b1}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_ACK, 8'hFF, 11'd2047, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, 8'h00, 8'h00, 1'b0}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, 8'h41, 11'd0, 1'b1,
      cursor_report_t'{7'd1, 5'd0, 11'd1, 8'h00, 8'h00, 1'b1}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd0, 1'b1,
      cursor_report_t'{7'd1, 5'd0, 11'd1, 8'h41, tcw_pkg::INIT_ATTR, 1'b1}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, 8'hFF, 11'd0, 1'b1,
      cursor_report_t'{7'd2, 5'd0, 11'd2, 8'h00, 8'h00, 1'b1}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, 8'h01, 11'd0, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, tcw_pkg::NEWLINE_CODE, 11'd0,
      1'b1, cursor_report_t'{7'd0, 5'd1, 11'd80, 8'h00, 8'h00, 1'b1}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, 8'h7F, 11'd0, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd80, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd2, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_ACK, 8'h00, 11'd0, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_CLEAR, 8'h00, 11'd0, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, 8'h00, 8'h00, 1'b1}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd1, 1'b1,
      cursor_report_t'{7'd0, 5'd0, 11'd0, tcw_pkg::SPACE_CODE, tcw_pkg::INIT_ATTR, 1'b1}});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, tcw_pkg::SPACE_CODE, 11'd0, 1'b0,
      '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_WRITE, 8'h80, 11'd0, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd1024, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd1023, 1'b0, '0});
    directed_rows.push_back(table_row_t'{tcw_pkg::ACT_READ, 8'h00, 11'd1, 1'b0, '0});

    foreach (directed_rows[i]) begin
      issue_item(directed_rows[i].act, directed_rows[i].ch, directed_rows[i].idx,
                 directed_rows[i].typed, directed_rows[i].want);
      idle_gap(1'b1);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_attrs(8'h00, 8'hFF);
        1: set_attrs(8'hFF, 8'h00);
        3: set_attrs(tcw_pkg::INIT_ATTR, tcw_pkg::INIT_ATTR);
        default: set_attrs(8'($urandom), 8'($urandom));
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        gaps_on = ($urandom_range(0, 9) >= 3);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // a line of text, now and then long enough to wrap
          len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(70, 90);
          for (int k = 0; k < len; k++) begin
            send(tcw_pkg::ACT_WRITE, 8'($urandom), 11'($urandom), gaps_on);
          end
          send(tcw_pkg::ACT_WRITE, tcw_pkg::NEWLINE_CODE, 11'($urandom), gaps_on);
          phase_items += len + 1;
        end else if (pick < 60) begin
          // newline burst to push the cursor down into scrolling
          len = $urandom_range(3, 12);
          for (int k = 0; k < len; k++) begin
            send(tcw_pkg::ACT_WRITE, tcw_pkg::NEWLINE_CODE, 11'($urandom), gaps_on);
          end
          phase_items += len;
        end else if (pick < 80) begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 3))
              0: begin
                pos  = shadow_row * tcw_pkg::COLUMNS + shadow_col;
                back = $urandom_range(0, 3);
                idx  = (pos >= back) ? 11'(pos - back) : 11'(pos);
              end
              1: idx = 11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
              2: idx = 11'($urandom_range(tcw_pkg::CELL_COUNT, 2047));
              default: idx = 11'(tcw_pkg::LAST_ROW * tcw_pkg::COLUMNS +
                                 $urandom_range(0, tcw_pkg::COLUMNS - 1));
            endcase
            send(tcw_pkg::ACT_READ, 8'($urandom), idx, gaps_on);
          end
          phase_items += len;
        end else if (pick < 90) begin
          send(tcw_pkg::ACT_ACK, 8'($urandom), 11'($urandom), gaps_on);
          send(tcw_pkg::ACT_WRITE, 8'($urandom), 11'($urandom), gaps_on);
          phase_items += 2;
        end else if (pick < 94) begin
          send(tcw_pkg::ACT_CLEAR, 8'($urandom), 11'($urandom), gaps_on);
          phase_items += 1;
        end else begin
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++) begin
            send(tcw_pkg::action_t'($urandom_range(0, 3)), 8'($urandom), 11'($urandom),
                 gaps_on);
          end
          phase_items += len;
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d reports still outstanding at the end", expected_reports.size());
      fail_count++;
    end

    $display("covered %0d items: %0d reads, %0d clears, %0d scrolls", items_issued,
             read_count, clear_count, scroll_count);
    $display("over %0d attribute settings, %0d mismatches", attr_settings, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
